### src/fir_filter_direct_form_unit_defines.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion helpers for the FIR filter unit.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_DIRECT_FORM_UNIT_DEFINES_SVH
`define FIR_FILTER_DIRECT_FORM_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is asserted
`define FIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also checks behavior across reset
`define FIR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fir_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, codes and the control bundle shared by the FIR filter modules.
// ----------------------------------------------------------------------------
package fir_pkg;

  // Default tap count
  localparam int TAPS_DEF    = 25;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int IDX_W       = 5;
  localparam int PROD_W      = SAMPLE_W + COEF_W;

  // Q1.15 rounding
  localparam int ROUND_SHIFT = 15;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
  localparam int OUT_MAX     = 32767;
  localparam int OUT_MIN     = -32768;

  // Request modes
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Control broadcast to every tap cell
  typedef struct packed {
    logic                     shift;
    logic                     coef_we;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } cell_ctrl_t;

endpackage

### src/fir_tap_cell.sv
// ----------------------------------------------------------------------------
// FIR tap cell
// One tap: delayed sample, coefficient, registered product and partial sum.
// ----------------------------------------------------------------------------
module fir_tap_cell
  import fir_pkg::*;
#(
  parameter int ACC_W = PROD_W + 6,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample_prev,
  input  logic signed [ACC_W-1:0]    psum_prev,
  output logic signed [SAMPLE_W-1:0] sample_q,
  output logic signed [ACC_W-1:0]    psum_q
);

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [COEF_W-1:0]   coef_r, coef_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    psum_r, psum_nxt;
  logic                       hit;

  // Coefficient write addressed to this tap
  assign hit = ctrl.coef_we && (32'(ctrl.coef_index) == 32'(IDX));

  // Next values: shift, coefficient load, product, partial sum
  always_comb begin
    sample_nxt = ctrl.shift ? sample_prev : sample_r;
    coef_nxt   = hit ? ctrl.coef_value : coef_r;
    prod_nxt   = sample_r * coef_r;
    psum_nxt   = psum_prev + ACC_W'(prod_r);
  end

  // Tap state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      coef_r   <= '0;
    end else begin
      sample_r <= sample_nxt;
      coef_r   <= coef_nxt;
    end
  end

  // Arithmetic pipeline
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    psum_r <= psum_nxt;
  end

  assign sample_q = sample_r;
  assign psum_q   = psum_r;

endmodule

### src/fir_round_sat.sv
// ----------------------------------------------------------------------------
// FIR round and saturate
// Rounds the accumulator half up, drops 15 fraction bits, clips to 16 bits.
// ----------------------------------------------------------------------------
module fir_round_sat
  import fir_pkg::*;
#(
  parameter int ACC_W = PROD_W + 6
) (
  input  logic signed [ACC_W-1:0]    acc,
  output logic signed [SAMPLE_W-1:0] result,
  output logic                       clipped
);

  localparam int Y_W = ACC_W + 1 - ROUND_SHIFT;
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(OUT_MAX);
  localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(OUT_MIN);

  logic signed [ACC_W:0]  biased;
  logic signed [Y_W-1:0]  y;

  // Add half an LSB, then floor by dropping fraction bits
  assign biased = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(ROUND_BIAS);
  assign y      = $signed(biased[ACC_W:ROUND_SHIFT]);

  // Clip to the 16-bit range
  always_comb begin
    priority if (y > Y_MAX) begin
      result  = SAMPLE_W'(OUT_MAX);
      clipped = 1'b1;
    end else if (y < Y_MIN) begin
      result  = SAMPLE_W'(OUT_MIN);
      clipped = 1'b1;
    end else begin
      result  = y[SAMPLE_W-1:0];
      clipped = 1'b0;
    end
  end

endmodule

### src/fir_filter_direct_form_unit.sv
// A sample request is accepted only while idle; the unit then stays busy, with
// in_stall high, until its result is loaded, the partial sum passing through
// the tap chain one cell per cycle; a coefficient write is also taken only while idle.
// Reset (synchronous, active low) clears the delay line, the coefficients
// and all handshake state.
// ----------------------------------------------------------------------------
// FIR filter unit
// Direct-form FIR filter built from a chain of tap cells with rounding.
// ----------------------------------------------------------------------------
`include "fir_filter_direct_form_unit_defines.svh"

module fir_filter_direct_form_unit
  import fir_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [IDX_W-1:0]           in_coef_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_filtered_sample,
  output logic                       out_saturated
);

  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int CNT_W = $clog2(TAPS + 2);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(TAPS + 1);

  cell_ctrl_t                 ctrl;
  logic                       in_take, out_take, done, load;
  logic                       busy_r, busy_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_sat_r, out_sat_nxt;
  logic signed [SAMPLE_W-1:0] rs_result;
  logic                       rs_clipped;
  logic signed [SAMPLE_W-1:0] sample_w [TAPS];
  logic signed [ACC_W-1:0]    psum_w   [TAPS];

  // Handshake
  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;
  assign out_take = out_valid_r && !out_stall;
  assign done     = busy_r && (cnt_r == CNT_DONE);
  assign load     = done && (!out_valid_r || !out_stall);

  // Control broadcast to the cells
  always_comb begin
    ctrl.shift      = in_take && (in_mode == MODE_SAMPLE);
    ctrl.coef_we    = in_take && (in_mode == MODE_COEF);
    ctrl.coef_index = in_coef_index;
    ctrl.coef_value = in_coef_value;
  end

  // Tap chain: samples move right, partial sums accumulate right
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    fir_tap_cell #(
      .ACC_W (ACC_W),
      .IDX   (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample_prev ((k == 0) ? in_sample_in : sample_w[(k == 0) ? 0 : k-1]),
      .psum_prev   ((k == 0) ? ACC_W'(0) : psum_w[(k == 0) ? 0 : k-1]),
      .sample_q    (sample_w[k]),
      .psum_q      (psum_w[k])
    );
  end

  // Rounding of the chain's final sum
  fir_round_sat #(
    .ACC_W (ACC_W)
  ) u_round (
    .acc     (psum_w[TAPS-1]),
    .result  (rs_result),
    .clipped (rs_clipped)
  );

  // Sequencer: busy from sample request until the result is loaded
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (ctrl.shift) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (load) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !done) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = rs_result;
      out_sat_nxt    = rs_clipped;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_saturated       = out_sat_r;

  // Checks
  `FIR_ASSERT(a_sample_starts, clk, rst_n, ctrl.shift |=> (busy_r && (cnt_r == '0)), "sample did not start")
  `FIR_ASSERT(a_load_valid, clk, rst_n, load |=> (out_valid_r && !busy_r), "result load lost")
  `FIR_ASSERT(a_no_coef_busy, clk, rst_n, busy_r |-> !ctrl.coef_we, "coefficient write while busy")
  `FIR_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (!out_valid_r && !busy_r), "reset did not clear")

endmodule

### sim/fir_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter checker
// Watches the request and result channels of the FIR filter unit, keeps its own copy of
// the delay line and the coefficient store, predicts each filtered sample and
// compares it with what the unit delivers.
// ----------------------------------------------------------------------------
module fir_checker
  import fir_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_mode,
  input  logic [IDX_W-1:0]           in_coef_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_filtered_sample,
  input  logic                       out_saturated,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;
  } filtered_t;

  logic signed [SAMPLE_W-1:0] taps_q [TAPS];
  logic signed [COEF_W-1:0]   coefs_q [TAPS];
  filtered_t                  filtered_q [$];

  // Shift one sample in and form the rounded, clipped dot product
  function automatic filtered_t filter_sample(input logic signed [SAMPLE_W-1:0] s);
    filtered_t r;
    longint    acc;
    longint    y;
    int        j;
    for (j = TAPS - 1; j > 0; j--) taps_q[j] = taps_q[j-1];
    taps_q[0] = s;
    acc = 0;
    for (j = 0; j < TAPS; j++) acc += longint'(coefs_q[j]) * longint'(taps_q[j]);
    // round half up, floor after the arithmetic shift
    y = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
    r.clipped = 1'b0;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      r.clipped = 1'b1;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      r.clipped = 1'b1;
    end
    r.value = y[SAMPLE_W-1:0];
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Track requests on both channels
  always @(posedge clk) begin
    filtered_t want;
    int        errs;
    errs = errors;
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        taps_q[k]  = '0;
        coefs_q[k] = '0;
      end
      filtered_q.delete();
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: result %0d/%0b with nothing expected", $time,
                   out_filtered_sample, out_saturated);
          errs++;
        end else begin
          want = filtered_q.pop_front();
          if (out_filtered_sample !== want.value) begin
            $display("%0t: filtered_sample expected %0d, actual %0d", $time,
                     want.value, out_filtered_sample);
            errs++;
          end
          if (out_saturated !== want.clipped) begin
            $display("%0t: saturated expected %0b, actual %0b", $time,
                     want.clipped, out_saturated);
            errs++;
          end
        end
      end
      // input side
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_SAMPLE) filtered_q.push_back(filter_sample(in_sample_in));
        else if (in_coef_index < TAPS) coefs_q[in_coef_index] = in_coef_value;
      end
    end
    errors  <= errs;
    pending <= filtered_q.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter testbench
// Drives coefficient writes and sample streams into the FIR filter unit with
// random gaps and result stalls, one long stall included, and leaves the
// checking to the checker that sits beside the unit.
// ----------------------------------------------------------------------------
module testbench;
  import fir_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int ITEMS       = 1500;
  localparam int CALM_ITEMS  = 200;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int LATENCY     = TAPS + 2;
  localparam int LIMIT       = 400000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_mode;
  logic [IDX_W-1:0]           in_coef_index;
  logic signed [COEF_W-1:0]   in_coef_value;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_filtered_sample;
  logic                       out_saturated;
  int                         errors;
  int                         pending;
  int                         sent_count;
  int                         cycle_count;
  logic                       calm;

  fir_filter_direct_form_unit #(.TAPS(TAPS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_sample (out_filtered_sample),
    .out_saturated       (out_saturated)
  );

  fir_checker #(.TAPS(TAPS)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_sample (out_filtered_sample),
    .out_saturated       (out_saturated),
    .errors              (errors),
    .pending             (pending)
  );

  assign calm = (sent_count >= ITEMS - CALM_ITEMS);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Sample values weighted toward the extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int t;
    case ($urandom_range(0, 5))
      0:       t = OUT_MAX;
      1:       t = OUT_MIN;
      2:       t = $urandom_range(0, 511) - 256;
      default: t = $urandom;
    endcase
    return t[SAMPLE_W-1:0];
  endfunction

  // Coefficients: narrow ones keep the sum in range, wide ones clip often
  function automatic logic signed [COEF_W-1:0] pick_coef(input logic narrow);
    int t;
    if (narrow) t = $urandom_range(0, 4095) - 2048;
    else begin
      case ($urandom_range(0, 5))
        0:       t = OUT_MAX;
        1:       t = OUT_MIN;
        2:       t = 0;
        default: t = $urandom;
      endcase
    end
    return t[COEF_W-1:0];
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(input logic m, input logic [IDX_W-1:0] idx,
                          input logic signed [COEF_W-1:0] cv,
                          input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_coef_index <= idx;
    in_coef_value <= cv;
    in_sample_in  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Result side stalls, with one long hold-off to back the unit up
  initial begin
    logic held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int   n;
    int   k;
    logic narrow;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_COEF;
    in_coef_index = '0;
    in_coef_value = '0;
    in_sample_in  = '0;
    sent_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // start of stream: all coefficients still zero
    send_req(MODE_SAMPLE, 5'd31, 16'sh7fff, 16'sh7fff);
    // clip high: -1.0 times the most negative sample
    send_req(MODE_COEF, 5'd0, 16'sh8000, 16'sh7fff);
    send_req(MODE_SAMPLE, 5'd0, 16'sh0000, 16'sh8000);
    // last tap and writes past the end, which are dropped
    send_req(MODE_COEF, 5'(TAPS - 1), 16'sh7fff, 16'sh8000);
    send_req(MODE_COEF, 5'(TAPS), 16'sh7fff, 16'sh0000);
    send_req(MODE_COEF, 5'd31, 16'sh8000, 16'shffff);
    // clip low: two taps of -1.0 on full-scale positive samples
    send_req(MODE_COEF, 5'd1, 16'sh8000, 16'sh1234);
    send_req(MODE_SAMPLE, 5'd31, 16'sh7fff, 16'sh7fff);
    send_req(MODE_SAMPLE, 5'd0, 16'sh8000, 16'sh7fff);
    // small values around the rounding point
    send_req(MODE_COEF, 5'd0, 16'sh4000, 16'sh0000);
    send_req(MODE_COEF, 5'd1, 16'sh0000, 16'sh0000);
    send_req(MODE_SAMPLE, 5'd10, 16'sh5555, 16'sh0001);
    send_req(MODE_SAMPLE, 5'd21, 16'shaaaa, 16'shffff);
    send_req(MODE_SAMPLE, 5'd0, 16'sh0000, 16'sh0003);
    // tail: zero samples shift into the delay line
    for (k = 0; k < 4; k++)
      send_req(MODE_SAMPLE, IDX_W'($urandom), COEF_W'($urandom), '0);

    // random blocks: reprogram some taps, stream samples, sometimes shift in zeros
    while (sent_count < ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        narrow = 1'($urandom_range(0, 1));
        n = $urandom_range(1, TAPS);
        for (k = 0; k < n; k++)
          send_req(MODE_COEF, IDX_W'($urandom_range(0, TAPS - 1)), pick_coef(narrow),
                   SAMPLE_W'($urandom));
      end
      if ($urandom_range(0, 7) == 0)
        send_req(MODE_COEF, IDX_W'($urandom_range(TAPS, 31)), COEF_W'($urandom),
                 SAMPLE_W'($urandom));
      n = $urandom_range(1, 40);
      for (k = 0; k < n; k++)
        send_req(MODE_SAMPLE, IDX_W'($urandom), COEF_W'($urandom), pick_sample());
      if ($urandom_range(0, 3) == 0)
        for (k = 0; k < TAPS - 1; k++)
          send_req(MODE_SAMPLE, IDX_W'($urandom), COEF_W'($urandom), '0);
    end
    in_valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/fir_pkg.sv
src/fir_tap_cell.sv
src/fir_round_sat.sv
src/fir_filter_direct_form_unit.sv
sim/fir_checker.sv
sim/testbench.sv
